// ===== hdl/scop_pkg.sv =====
// Shared types, constants and helper functions of the slab clip projector.
`default_nettype none

package scop_pkg;

    localparam int MARGIN   = 5;
    localparam int EXT_TRIM = 2 * MARGIN;
    localparam int LANES    = 4;
    localparam int SCR_W    = 16;
    localparam int VAL_W    = 32;
    localparam int ADJ_W    = 34;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [30:0] SCALE_RST = 31'd65536;
    localparam logic [2:0]  VIEW_RST  = 3'd5;

    typedef enum logic [2:0] {
        VIEW_BACK_X,
        VIEW_BACK_Y,
        VIEW_BACK_Z,
        VIEW_FRONT_X,
        VIEW_FRONT_Y,
        VIEW_FRONT_Z
    } t_view;

    typedef enum logic [2:0] {
        REG_VIEW_MODE,
        REG_SLAB_LOW,
        REG_SLAB_HIGH,
        REG_SCALE,
        REG_OFFSET_X,
        REG_OFFSET_Y,
        REG_OFFSET_Z,
        REG_WINDOW_SIZE
    } t_reg_idx;

    typedef struct packed {
        logic       valid;
        logic [1:0] axis;
        logic [1:0] src_x;
        logic       mir_x;
        logic [1:0] src_y;
        logic       mir_y;
    } t_mode;

    typedef struct packed {
        logic [2:0]        view_mode;
        logic [30:0]       scale;
        logic [2:0][31:0]  offset;
        logic [31:0]       window_size;
    } t_cfg;

    typedef struct packed {
        logic        bond;
        logic [15:0] diam;
        logic        ends;
        logic        kept;
    } t_side;

    typedef struct packed {
        logic        last;
        logic        kept;
        logic [15:0] count;
        logic [15:0] marker;
        logic [15:0] y2;
        logic [15:0] x2;
        logic [15:0] y1;
        logic [15:0] x1;
    } t_result;

    function automatic t_mode mode_lookup(input logic [2:0] mode);
        t_mode m;
        m = '0;
        unique case (t_view'(mode))
            VIEW_BACK_X:  m = '{1'b1, AXIS_X, AXIS_Z, 1'b1, AXIS_Y, 1'b1};
            VIEW_BACK_Y:  m = '{1'b1, AXIS_Y, AXIS_X, 1'b0, AXIS_Z, 1'b0};
            VIEW_BACK_Z:  m = '{1'b1, AXIS_Z, AXIS_X, 1'b0, AXIS_Y, 1'b1};
            VIEW_FRONT_X: m = '{1'b1, AXIS_X, AXIS_Z, 1'b0, AXIS_Y, 1'b1};
            VIEW_FRONT_Y: m = '{1'b1, AXIS_Y, AXIS_X, 1'b0, AXIS_Z, 1'b1};
            VIEW_FRONT_Z: m = '{1'b1, AXIS_Z, AXIS_X, 1'b0, AXIS_Y, 1'b0};
            default:      m = '0;
        endcase
        return m;
    endfunction

    function automatic logic [15:0] sat16(input logic signed [ADJ_W-1:0] v);
        logic [15:0] r;
        if (v > 34'sd32767) begin
            r = 16'h7fff;
        end else if (v < -34'sd32768) begin
            r = 16'h8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/scop_cfg.sv =====
// Configuration register file behind the APB-style port.
`default_nettype none

module scop_cfg #(
    parameter int COORD_BITS = 32,
    localparam int DATA_W = (COORD_BITS > 32) ? 64 : 32,
    localparam int ADDR_LO = (COORD_BITS > 32) ? 3 : 2,
    localparam int ADDR_W = ADDR_LO + 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ADDR_W-1:0]            paddr,
    input  logic [DATA_W-1:0]            pwdata,
    output logic [DATA_W-1:0]            prdata,
    output logic                         pready,
    output scop_pkg::t_cfg               o_cfg,
    output logic signed [COORD_BITS-1:0] o_slab_low,
    output logic signed [COORD_BITS-1:0] o_slab_high
);
    import scop_pkg::*;

    localparam logic signed [63:0] LOW64  = -64'sd2147483648;
    localparam logic signed [63:0] HIGH64 = 64'sd2147483647;
    localparam logic [COORD_BITS-1:0] LOW_RST =
        (COORD_BITS >= 32) ? LOW64[COORD_BITS-1:0] : {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic [COORD_BITS-1:0] HIGH_RST =
        (COORD_BITS >= 32) ? HIGH64[COORD_BITS-1:0] : {1'b0, {(COORD_BITS-1){1'b1}}};

    t_cfg                         r_cfg;
    logic signed [COORD_BITS-1:0] r_low;
    logic signed [COORD_BITS-1:0] r_high;
    t_reg_idx                     w_idx;
    logic                         w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:ADDR_LO]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.view_mode   <= VIEW_RST;
            r_cfg.scale       <= SCALE_RST;
            r_cfg.offset      <= '0;
            r_cfg.window_size <= '0;
            r_low             <= LOW_RST;
            r_high            <= HIGH_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_VIEW_MODE:   r_cfg.view_mode   <= pwdata[2:0];
                REG_SLAB_LOW:    r_low             <= pwdata[COORD_BITS-1:0];
                REG_SLAB_HIGH:   r_high            <= pwdata[COORD_BITS-1:0];
                REG_SCALE:       r_cfg.scale       <= pwdata[30:0];
                REG_OFFSET_X:    r_cfg.offset[0]   <= pwdata[31:0];
                REG_OFFSET_Y:    r_cfg.offset[1]   <= pwdata[31:0];
                REG_OFFSET_Z:    r_cfg.offset[2]   <= pwdata[31:0];
                REG_WINDOW_SIZE: r_cfg.window_size <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_VIEW_MODE:   prdata = DATA_W'(r_cfg.view_mode);
            REG_SLAB_LOW:    prdata = DATA_W'(r_low);
            REG_SLAB_HIGH:   prdata = DATA_W'(r_high);
            REG_SCALE:       prdata = DATA_W'(r_cfg.scale);
            REG_OFFSET_X:    prdata = DATA_W'($signed(r_cfg.offset[0]));
            REG_OFFSET_Y:    prdata = DATA_W'($signed(r_cfg.offset[1]));
            REG_OFFSET_Z:    prdata = DATA_W'($signed(r_cfg.offset[2]));
            REG_WINDOW_SIZE: prdata = DATA_W'(r_cfg.window_size);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg       = r_cfg;
    assign o_slab_low  = r_low;
    assign o_slab_high = r_high;

endmodule

`default_nettype wire

// ===== hdl/scop_lane.sv =====
// One projection lane: scale, offset, mirror and truncate a single coordinate.
`default_nettype none

module scop_lane #(
    parameter int COORD_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [COORD_BITS-1:0] i_coord,
    input  logic [30:0]                  i_scale,
    input  logic signed [31:0]           i_offset,
    input  logic                         i_mirror,
    input  logic signed [16:0]           i_extent,
    output logic signed [31:0]           o_value
);
    import scop_pkg::*;

    localparam int HI_W  = COORD_BITS - 16;
    localparam int PHI_W = HI_W + 31;
    localparam int SUM_W = (COORD_BITS + 31 > 61) ? COORD_BITS + 31 : 61;
    localparam logic [SUM_W-1:0] LIMIT = SUM_W'(64'h1000_0000_0000_0000);

    logic                   r_neg_a, r_neg_b, r_neg_c;
    logic [COORD_BITS-1:0]  r_mag, n_mag;
    logic [PHI_W-1:0]       r_phi;
    logic [46:0]            r_plo;
    logic [SUM_W-1:0]       n_sum;
    logic [60:0]            r_prod, n_prod;
    logic signed [63:0]     n_sprod, n_v2, r_v2, n_v3, r_v3, n_v4;
    logic signed [VAL_W-1:0] r_val;

    assign n_mag   = i_coord[COORD_BITS-1] ? (~i_coord + 1'b1) : i_coord;
    assign n_sum   = (SUM_W'(r_phi) << 16) + SUM_W'(r_plo);
    assign n_prod  = (n_sum > LIMIT) ? LIMIT[60:0] : n_sum[60:0];
    assign n_sprod = r_neg_c ? -$signed({3'b000, r_prod}) : $signed({3'b000, r_prod});
    assign n_v2    = n_sprod + $signed({{16{i_offset[31]}}, i_offset, 16'h0000});
    assign n_v3    = i_mirror ? ($signed({{15{i_extent[16]}}, i_extent, 32'h0}) - r_v2)
                              : r_v2;
    assign n_v4    = r_v3 + (r_v3[63] ? 64'sh0000_0000_FFFF_FFFF : 64'sh0);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg_a <= i_coord[COORD_BITS-1];
            r_mag   <= n_mag;
            r_neg_b <= r_neg_a;
            r_phi   <= PHI_W'(r_mag[COORD_BITS-1:16]) * PHI_W'(i_scale);
            r_plo   <= 47'(r_mag[15:0]) * 47'(i_scale);
            r_neg_c <= r_neg_b;
            r_prod  <= n_prod;
            r_v2    <= n_v2;
            r_v3    <= n_v3;
            r_val   <= n_v4[63:32];
        end
    end

    assign o_value = r_val;

endmodule

`default_nettype wire

// ===== hdl/scop_merge.sv =====
// Merge stage: margin, centring, saturation, kept count and output skid buffer.
`default_nettype none

module scop_merge (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  scop_pkg::t_side                  i_side,
    input  logic [scop_pkg::LANES-1:0][31:0] i_value,
    output logic                             o_ready,
    output logic                             o_tvalid,
    input  logic                             i_tready,
    output logic [95:0]                      o_tdata,
    output logic                             o_tuser,
    output logic                             o_tlast
);
    import scop_pkg::*;

    logic [15:0]             r_cnt, n_cnt;
    logic [15:0]             w_half;
    logic signed [ADJ_W-1:0] w_bias;
    logic signed [ADJ_W-1:0] w_adj [LANES];
    t_result                 n_res, r_out, r_skid;
    logic                    r_ov, r_sv, w_take;

    assign w_half = i_side.diam >> 1;
    assign w_bias = i_side.bond ? ADJ_W'(MARGIN)
                                : ADJ_W'(MARGIN) - $signed({18'h0, w_half});
    assign n_cnt  = (i_side.kept && (r_cnt != 16'hFFFF)) ? r_cnt + 16'd1 : r_cnt;

    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            w_adj[j] = $signed({{2{i_value[j][31]}}, i_value[j]}) + w_bias;
        end
        n_res       = '0;
        n_res.last  = i_side.ends;
        n_res.kept  = i_side.kept;
        n_res.count = n_cnt;
        if (i_side.kept) begin
            n_res.x1 = sat16(w_adj[0]);
            n_res.y1 = sat16(w_adj[1]);
            if (i_side.bond) begin
                n_res.x2 = sat16(w_adj[2]);
                n_res.y2 = sat16(w_adj[3]);
            end else begin
                n_res.marker = i_side.diam;
            end
        end
    end

    assign o_ready = !r_sv;
    assign w_take  = r_ov && i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ov  <= 1'b0;
            r_sv  <= 1'b0;
        end else begin
            if (o_ready && i_valid) begin
                r_cnt <= i_side.ends ? 16'd0 : n_cnt;
            end
            if (r_sv) begin
                if (w_take) begin
                    r_out <= r_skid;
                    r_sv  <= 1'b0;
                end
            end else if (i_valid) begin
                if (!r_ov || w_take) begin
                    r_out <= n_res;
                    r_ov  <= 1'b1;
                end else begin
                    r_skid <= n_res;
                    r_sv   <= 1'b1;
                end
            end else if (w_take) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_tvalid = r_ov;
    assign o_tdata  = {r_out.count, r_out.marker, r_out.y2, r_out.x2, r_out.y1, r_out.x1};
    assign o_tuser  = r_out.kept;
    assign o_tlast  = r_out.last;

endmodule

`default_nettype wire

// ===== hdl/slab_clip_ortho_projector_unit.sv =====
// Top level of the slab clip orthographic projector.
// Throughput: one beat per cycle while the output does not stall, four projection lanes in a six-stage pipeline.
// Stalls come only from the output side; a two-entry output buffer decouples tready.
// Reset (synchronous, active low) restores register defaults and clears the kept count.
`default_nettype none

module slab_clip_ortho_projector_unit #(
    parameter int COORD_BITS = 32,
    localparam int DATA_W = (COORD_BITS > 32) ? 64 : 32,
    localparam int ADDR_W = ((COORD_BITS > 32) ? 3 : 2) + 3,
    localparam int IN_W = ((6 * COORD_BITS + 16 + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, diameter, zero fill
    input  logic [IN_W-1:0]   i_s_tdata,
    // action
    input  logic              i_s_tuser,
    input  logic              i_s_tlast,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // screen_x1, screen_y1, screen_x2, screen_y2, marker_size, kept_count
    output logic [95:0]       o_m_tdata,
    // kept
    output logic              o_m_tuser,
    output logic              o_m_tlast,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);
    import scop_pkg::*;

    localparam int DEPTH = 6;

    t_cfg                         w_cfg;
    logic signed [COORD_BITS-1:0] w_low, w_high;
    logic signed [COORD_BITS-1:0] w_pa [3];
    logic signed [COORD_BITS-1:0] w_pb [3];
    t_mode                        w_mode;
    logic signed [16:0]           w_ew, w_eh;
    logic                         w_in_a, w_in_b, w_en;
    t_side                        n_side;
    t_side                        r_side [DEPTH];
    logic [DEPTH-1:0]             r_vld;
    logic [LANES-1:0][31:0]       w_value;

    scop_cfg #(.COORD_BITS(COORD_BITS)) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_cfg       (w_cfg),
        .o_slab_low  (w_low),
        .o_slab_high (w_high)
    );

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_pa[k] = i_s_tdata[k * COORD_BITS +: COORD_BITS];
            w_pb[k] = i_s_tdata[(k + 3) * COORD_BITS +: COORD_BITS];
        end
    end

    assign w_mode = mode_lookup(w_cfg.view_mode);
    assign w_ew   = $signed({1'b0, w_cfg.window_size[31:16]}) - 17'(EXT_TRIM);
    assign w_eh   = $signed({1'b0, w_cfg.window_size[15:0]}) - 17'(EXT_TRIM);
    assign w_in_a = (w_pa[w_mode.axis] >= w_low) && (w_pa[w_mode.axis] <= w_high);
    assign w_in_b = (w_pb[w_mode.axis] >= w_low) && (w_pb[w_mode.axis] <= w_high);

    assign n_side.bond = i_s_tuser;
    assign n_side.diam = i_s_tdata[6 * COORD_BITS +: 16];
    assign n_side.ends = i_s_tlast;
    assign n_side.kept = w_mode.valid && w_in_a && (!i_s_tuser || w_in_b);

    assign o_s_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_s_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= n_side;
            for (int s = 1; s < DEPTH; s++) begin
                r_side[s] <= r_side[s-1];
            end
        end
    end

    for (genvar j = 0; j < LANES; j++) begin : g_lane
        localparam bit IS_Y = (j % 2) == 1;
        localparam bit IS_B = j >= 2;
        logic [1:0] w_src;
        assign w_src = IS_Y ? w_mode.src_y : w_mode.src_x;

        scop_lane #(.COORD_BITS(COORD_BITS)) u_lane (
            .i_clk    (i_clk),
            .i_en     (w_en),
            .i_coord  (IS_B ? w_pb[w_src] : w_pa[w_src]),
            .i_scale  (w_cfg.scale),
            .i_offset ($signed(w_cfg.offset[w_src])),
            .i_mirror (IS_Y ? w_mode.mir_y : w_mode.mir_x),
            .i_extent (IS_Y ? w_eh : w_ew),
            .o_value  (w_value[j])
        );
    end

    scop_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_vld[DEPTH-1]),
        .i_side   (r_side[DEPTH-1]),
        .i_value  (w_value),
        .o_ready  (w_en),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata),
        .o_tuser  (o_m_tuser),
        .o_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire
